/* design/sis_pkg.sv */
// Shared types and constants for the SIS epidemic graph step block.
// No dependencies; imported by sis_epidemic_graph_step_top.
package sis_pkg;

	// default sizing
	localparam int MAX_NODES_DEF  = 256;
	localparam int MAX_DEGREE_DEF = 32;
	localparam int DRAW_BITS_DEF  = 16;

	// fixed field widths
	localparam int CMD_W   = 2;
	localparam int NODE_W  = 8;
	localparam int THR_W   = 16;
	localparam int NC_W    = 9;
	localparam int COUNT_W = 9;
	localparam int ROUND_W = 24;
	localparam int LFSR_W  = 32;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [LFSR_W-1:0]  LFSR_TAPS = 32'h8020_0003;
	localparam logic [ROUND_W-1:0] ROUND_MAX = 24'hFF_FFFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INFECT_THR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd3;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD_EDGE   = 2'd0,
		CMD_SET_STATE  = 2'd1,
		CMD_RUN_ROUND  = 2'd2,
		CMD_READ_STATE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_READ,
		ST_E_RDB,
		ST_E_CHK,
		ST_E_WRB,
		ST_N_RD,
		ST_N_DEC,
		ST_SLOT,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_COMMIT,
		ST_COMMIT_END,
		ST_REPLY
	} st_t;

endpackage

/* design/sis_epidemic_graph_step_top.sv */
// SIS epidemic graph step: command sequencer, graph stores, LFSR draw unit.
// Depends on sis_pkg.
//
// Usage
//   Commands enter on start/cmd/node_a/node_b/state_value; an item is taken
//   at a clock edge where start is high and busy is low. busy stays high
//   until the result goes out. Every item yields one result item, shown for
//   exactly one cycle with done high: status, node_state, infected_count,
//   alive, round_number. The receiver cannot stall; it must take the item
//   in the done cycle. busy is already low in that cycle, so the next
//   command may be taken at the same edge that the result is.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata, one register
//   per cycle; the user must write only while no command is in flight, as the
//   block itself does not enforce it.
// Run round
//   Each active node is read; an infected node or one with no neighbors is
//   decided directly, a susceptible node walks its neighbor slots. The slot
//   walk issues one draw and one neighbor-list read per cycle; the state copy
//   at the end of the round moves one node per cycle through the single state
//   write port.
// Reset
//   arst_n clears control state, loads the LFSR with 1 and starts a clearing
//   pass over the state and degree stores; busy is high for that time. Config
//   writes are taken during the pass.
module sis_epidemic_graph_step_top #(
	parameter int MAX_NODES  = sis_pkg::MAX_NODES_DEF,
	parameter int MAX_DEGREE = sis_pkg::MAX_DEGREE_DEF,
	parameter int DRAW_BITS  = sis_pkg::DRAW_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [sis_pkg::CMD_W-1:0]       cmd,
	input  logic [sis_pkg::NODE_W-1:0]      node_a,
	input  logic [sis_pkg::NODE_W-1:0]      node_b,
	input  logic                            state_value,
	input  logic                            cfg_we,
	input  logic [sis_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sis_pkg::CFG_W-1:0]       cfg_wdata,
	output logic                            done,
	output logic                            status,
	output logic                            node_state,
	output logic [sis_pkg::COUNT_W-1:0]     infected_count,
	output logic                            alive,
	output logic [sis_pkg::ROUND_W-1:0]     round_number
);
	import sis_pkg::*;

	localparam int NW     = $clog2(MAX_NODES);
	localparam int NCW    = $clog2(MAX_NODES + 1);
	localparam int DW     = $clog2(MAX_DEGREE + 1);
	localparam int DEPTH_L = MAX_NODES * MAX_DEGREE;
	localparam int LW     = $clog2(DEPTH_L);

	// ---------------- registers ----------------
	st_t               state_q, state_d;
	logic [NCW-1:0]    idx_q;
	logic              v_s1, v_s2, cv_s1;
	logic              below_s1;
	logic [NW-1:0]     cidx_s1;
	logic              done_q;
	logic [NCW-1:0]    count_q, sum_q;
	logic [ROUND_W-1:0] round_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic [THR_W-1:0]  inf_thr_q, rec_thr_q;
	logic [NC_W-1:0]   node_count_q;

	cmd_t              cmd_q;
	logic [NODE_W-1:0] a_q, b_q;
	logic              sv_q;
	logic              status_q, rd_q;
	logic [DW-1:0]     dega_q, degb_q, deg_q, slot_q;
	logic              hit_q;
	logic [LW-1:0]     base_q;

	// ---------------- memories ----------------
	logic              cur_mem [MAX_NODES];
	logic              nxt_mem [MAX_NODES];
	logic [DW-1:0]     deg_mem [MAX_NODES];
	logic [NODE_W-1:0] nbr_mem [DEPTH_L];

	logic              cur_re, cur_we, cur_wdata, cur_rd;
	logic [NW-1:0]     cur_raddr, cur_waddr;
	logic              nxt_re, nxt_we, nxt_wdata, nxt_rd;
	logic [NW-1:0]     nxt_raddr, nxt_waddr;
	logic              deg_re, deg_we;
	logic [NW-1:0]     deg_raddr, deg_waddr;
	logic [DW-1:0]     deg_wdata, deg_rd;
	logic              nbr_re, nbr_we;
	logic [LW-1:0]     nbr_raddr, nbr_waddr;
	logic [NODE_W-1:0] nbr_wdata, nbr_rd;

	// ---------------- derived values ----------------
	logic              accept;
	logic [31:0]       nc_wide;
	logic [NCW-1:0]    n_eff;
	logic              a_ok, b_ok, nb_ok;
	logic [NW+NODE_W-1:0] a_wide, b_wide, nb_wide;
	logic [NW-1:0]     a_idx, b_idx, nb_idx, node_idx;
	logic              node_last, clr_last, slot_last;
	logic              self_loop, edge_rej;
	logic [LW-1:0]     addr_a, addr_b;
	logic [LFSR_W-1:0] lfsr_nx;
	logic [DRAW_BITS-1:0] draw;
	logic [THR_W-1:0]  thr;
	logic              below;
	logic              lfsr_step, node_done, go_slots, hit_final;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// effective node count: 0 acts as 1, clamp at capacity
	assign nc_wide = 32'(node_count_q);
	always_comb begin
		if (nc_wide == 32'd0)
			n_eff = NCW'(1);
		else if (nc_wide > 32'(MAX_NODES))
			n_eff = NCW'(MAX_NODES);
		else
			n_eff = NCW'(nc_wide);
	end

	assign a_ok  = 32'(a_q) < 32'(n_eff);
	assign b_ok  = 32'(b_q) < 32'(n_eff);
	assign nb_ok = 32'(nbr_rd) < 32'(n_eff);

	// node fields to store index width (only used once range-checked)
	assign a_wide   = {{NW{1'b0}}, a_q};
	assign b_wide   = {{NW{1'b0}}, b_q};
	assign nb_wide  = {{NW{1'b0}}, nbr_rd};
	assign a_idx    = a_wide[NW-1:0];
	assign b_idx    = b_wide[NW-1:0];
	assign nb_idx   = nb_wide[NW-1:0];
	assign node_idx = idx_q[NW-1:0];

	assign node_last = (32'(idx_q) + 32'd1) == 32'(n_eff);
	assign clr_last  = 32'(idx_q) == 32'(MAX_NODES - 1);
	assign slot_last = (32'(slot_q) + 32'd1) == 32'(deg_q);

	// edge capacity check; deg_rd holds the degree of node_b here
	assign self_loop = (a_q == b_q);
	assign edge_rej  = self_loop ? ((32'(dega_q) + 32'd2) > 32'(MAX_DEGREE))
	                             : ((32'(dega_q) >= 32'(MAX_DEGREE)) ||
	                                (32'(deg_rd) >= 32'(MAX_DEGREE)));
	assign addr_a = LW'(32'(a_idx) * 32'(MAX_DEGREE) + 32'(dega_q));
	assign addr_b = LW'(32'(b_idx) * 32'(MAX_DEGREE) + 32'(degb_q));

	// draw unit: one Galois shift, top bits compared as a fraction
	assign lfsr_nx = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);
	assign draw    = lfsr_nx[LFSR_W-1 -: DRAW_BITS];
	assign thr     = (state_q == ST_SLOT) ? inf_thr_q : rec_thr_q;
	assign below   = {draw, THR_W'(0)} < {thr, DRAW_BITS'(0)};

	// susceptible node with neighbors walks its slots
	assign go_slots  = (state_q == ST_N_DEC) && !cur_rd && (deg_rd != '0);
	assign node_done = ((state_q == ST_N_DEC) && !go_slots) || (state_q == ST_DRAIN2);
	assign lfsr_step = ((state_q == ST_N_DEC) && cur_rd) || (state_q == ST_SLOT);
	assign hit_final = hit_q | (v_s2 & cur_rd);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:      if (clr_last) state_d = ST_IDLE;
			ST_IDLE:       if (start) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				case (cmd_q)
					CMD_ADD_EDGE:   state_d = (a_ok && b_ok) ? ST_E_RDB : ST_REPLY;
					CMD_SET_STATE:  state_d = ST_REPLY;
					CMD_RUN_ROUND:  state_d = ST_N_RD;
					CMD_READ_STATE: state_d = a_ok ? ST_READ : ST_REPLY;
					default:        state_d = ST_REPLY;
				endcase
			end
			ST_READ:       state_d = ST_REPLY;
			ST_E_RDB:      state_d = ST_E_CHK;
			ST_E_CHK:      state_d = edge_rej ? ST_REPLY : ST_E_WRB;
			ST_E_WRB:      state_d = ST_REPLY;
			ST_N_RD:       state_d = ST_N_DEC;
			ST_N_DEC: begin
				if (go_slots)
					state_d = ST_SLOT;
				else
					state_d = node_last ? ST_COMMIT : ST_N_RD;
			end
			ST_SLOT:       if (slot_last) state_d = ST_DRAIN1;
			ST_DRAIN1:     state_d = ST_DRAIN2;
			ST_DRAIN2:     state_d = node_last ? ST_COMMIT : ST_N_RD;
			ST_COMMIT:     if (node_last) state_d = ST_COMMIT_END;
			ST_COMMIT_END: state_d = ST_REPLY;
			ST_REPLY:      state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// ---------------- memory controls ----------------
	always_comb begin
		cur_re = 1'b0; cur_raddr = '0; cur_we = 1'b0; cur_waddr = '0; cur_wdata = 1'b0;
		nxt_re = 1'b0; nxt_raddr = '0; nxt_we = 1'b0; nxt_waddr = '0; nxt_wdata = 1'b0;
		deg_re = 1'b0; deg_raddr = '0; deg_we = 1'b0; deg_waddr = '0; deg_wdata = '0;
		nbr_re = 1'b0; nbr_raddr = '0; nbr_we = 1'b0; nbr_waddr = '0; nbr_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				cur_we = 1'b1; cur_waddr = node_idx;
				deg_we = 1'b1; deg_waddr = node_idx;
			end
			ST_DISPATCH: begin
				case (cmd_q)
					CMD_ADD_EDGE: begin
						deg_re = a_ok && b_ok; deg_raddr = a_idx;
					end
					CMD_SET_STATE: begin
						cur_we = a_ok; cur_waddr = a_idx; cur_wdata = sv_q;
					end
					CMD_READ_STATE: begin
						cur_re = a_ok; cur_raddr = a_idx;
					end
					default: ;
				endcase
			end
			ST_E_RDB: begin
				deg_re = 1'b1; deg_raddr = b_idx;
			end
			ST_E_CHK: begin
				nbr_we = !edge_rej; nbr_waddr = addr_a; nbr_wdata = b_q;
				deg_we = !edge_rej; deg_waddr = a_idx;
				deg_wdata = DW'(32'(dega_q) + 32'd1);
			end
			ST_E_WRB: begin
				nbr_we = 1'b1; nbr_waddr = addr_b; nbr_wdata = a_q;
				deg_we = 1'b1; deg_waddr = b_idx;
				deg_wdata = DW'(32'(degb_q) + 32'd1);
			end
			ST_N_RD: begin
				cur_re = 1'b1; cur_raddr = node_idx;
				deg_re = 1'b1; deg_raddr = node_idx;
			end
			ST_N_DEC: begin
				nxt_we = !go_slots; nxt_waddr = node_idx;
				nxt_wdata = cur_rd && !below;
			end
			ST_SLOT: begin
				nbr_re = 1'b1; nbr_raddr = base_q + LW'(slot_q);
			end
			ST_DRAIN2: begin
				nxt_we = 1'b1; nxt_waddr = node_idx; nxt_wdata = hit_final;
			end
			ST_COMMIT: begin
				nxt_re = 1'b1; nxt_raddr = node_idx;
			end
			default: ;
		endcase
		// slot pipeline: look up the neighbor's state on a hit draw
		if (v_s1 && below_s1 && nb_ok) begin
			cur_re = 1'b1; cur_raddr = nb_idx;
		end
		// commit pipeline: copy buffered state into the live store
		if (cv_s1) begin
			cur_we = 1'b1; cur_waddr = cidx_s1; cur_wdata = nxt_rd;
		end
	end

	// ---------------- stores ----------------
	always_ff @(posedge clk) begin
		if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
		if (cur_re) cur_rd <= cur_mem[cur_raddr];
	end

	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
		if (nxt_re) nxt_rd <= nxt_mem[nxt_raddr];
	end

	always_ff @(posedge clk) begin
		if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
		if (deg_re) deg_rd <= deg_mem[deg_raddr];
	end

	always_ff @(posedge clk) begin
		if (nbr_we) nbr_mem[nbr_waddr] <= nbr_wdata;
		if (nbr_re) nbr_rd <= nbr_mem[nbr_raddr];
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			idx_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			cv_s1        <= 1'b0;
			done_q       <= 1'b0;
			count_q      <= '0;
			round_q      <= '0;
			lfsr_q       <= LFSR_W'(1);
			inf_thr_q    <= '0;
			rec_thr_q    <= '0;
			node_count_q <= NC_W'(256);
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_REPLY);
			v_s1    <= (state_q == ST_SLOT);
			v_s2    <= v_s1 && below_s1 && nb_ok;
			cv_s1   <= (state_q == ST_COMMIT);

			if (state_q == ST_CLEAR)
				idx_q <= clr_last ? '0 : NCW'(32'(idx_q) + 32'd1);
			else if (state_q == ST_DISPATCH)
				idx_q <= '0;
			else if (node_done || state_q == ST_COMMIT)
				idx_q <= node_last ? '0 : NCW'(32'(idx_q) + 32'd1);

			if (state_q == ST_COMMIT_END) begin
				count_q <= NCW'(32'(sum_q) + 32'(nxt_rd));
				if (round_q != ROUND_MAX)
					round_q <= round_q + ROUND_W'(1);
			end

			if (lfsr_step)
				lfsr_q <= lfsr_nx;

			if (cfg_we) begin
				case (cfg_index)
					CFG_INFECT_THR:  inf_thr_q <= cfg_wdata[THR_W-1:0];
					CFG_RECOVER_THR: rec_thr_q <= cfg_wdata[THR_W-1:0];
					CFG_RNG_SEED:    lfsr_q <= (cfg_wdata == '0) ? LFSR_W'(1)
					                                             : cfg_wdata[LFSR_W-1:0];
					CFG_NODE_COUNT:  node_count_q <= cfg_wdata[NC_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		below_s1 <= below;
		cidx_s1  <= node_idx;

		if (accept) begin
			cmd_q    <= cmd_t'(cmd);
			a_q      <= node_a;
			b_q      <= node_b;
			sv_q     <= state_value;
			status_q <= 1'b0;
			rd_q     <= 1'b0;
		end

		case (state_q)
			ST_DISPATCH: begin
				base_q <= '0;
				sum_q  <= '0;
				case (cmd_q)
					CMD_ADD_EDGE:   status_q <= !(a_ok && b_ok);
					CMD_SET_STATE:  status_q <= !a_ok;
					CMD_READ_STATE: status_q <= !a_ok;
					default: ;
				endcase
			end
			ST_READ:  rd_q <= cur_rd;
			ST_E_RDB: dega_q <= deg_rd;
			ST_E_CHK: begin
				status_q <= edge_rej;
				// a self loop takes the slot after the one just written
				degb_q <= self_loop ? DW'(32'(dega_q) + 32'd1) : deg_rd;
			end
			ST_N_DEC: begin
				deg_q  <= deg_rd;
				slot_q <= '0;
			end
			ST_SLOT:  slot_q <= DW'(32'(slot_q) + 32'd1);
			default: ;
		endcase

		if (node_done)
			base_q <= LW'(32'(base_q) + 32'(MAX_DEGREE));

		if (state_q == ST_N_DEC)
			hit_q <= 1'b0;
		else
			hit_q <= hit_final;

		if (cv_s1 && state_q == ST_COMMIT)
			sum_q <= NCW'(32'(sum_q) + 32'(nxt_rd));
	end

	// ---------------- result ports ----------------
	assign done           = done_q;
	assign status         = status_q;
	assign node_state     = rd_q;
	assign infected_count = COUNT_W'(count_q);
	assign alive          = (count_q != '0);
	assign round_number   = round_q;

endmodule

/* bench/tb_sis_epidemic_graph_step_top.sv */
// Self-checking bench for the SIS epidemic graph step block: command driver,
// result monitor and an item-level predictor of graph, states, LFSR and round count.
// Depends on sis_pkg and sis_epidemic_graph_step_top.
`timescale 1ns / 100ps

module tb_sis_epidemic_graph_step_top;
	import sis_pkg::*;

	// About a hundred items, full-size worst-case rounds included, plus the reset
	// clearing pass stay far below this.
	localparam int unsigned CYCLE_LIMIT = 5_000_000;
	localparam int unsigned TAIL_CYCLES = 50;

	typedef enum logic [1:0] {
		OP_CMD,
		OP_CFG,
		OP_DRAIN
	} op_kind_t;

	// one entry of the stimulus list: a command item, a register write or a pause
	typedef struct {
		op_kind_t              kind;
		cmd_t                  op;
		logic [NODE_W-1:0]     a;
		logic [NODE_W-1:0]     b;
		logic                  sv;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_W-1:0]      data;
		int unsigned           gap_pct;
	} bench_op_t;

	typedef struct {
		logic                  status;
		logic                  node_state;
		logic [COUNT_W-1:0]    infected_count;
		logic                  alive;
		logic [ROUND_W-1:0]    round_number;
	} sis_reply_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [CMD_W-1:0]       cmd = '0;
	logic [NODE_W-1:0]      node_a = '0;
	logic [NODE_W-1:0]      node_b = '0;
	logic                   state_value = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   done;
	logic                   status;
	logic                   node_state;
	logic [COUNT_W-1:0]     infected_count;
	logic                   alive;
	logic [ROUND_W-1:0]     round_number;

	sis_epidemic_graph_step_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.node_a         (node_a),
		.node_b         (node_b),
		.state_value    (state_value),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.status         (status),
		.node_state     (node_state),
		.infected_count (infected_count),
		.alive          (alive),
		.round_number   (round_number)
	);

	always #5 clk = ~clk;

	bench_op_t   pending_ops[$];
	sis_reply_t  expected_replies[$];
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned gap_now = 13;

	// ------------------------------------------------------------------
	// Predictor: its own copy of the graph, node states and registers.
	// ------------------------------------------------------------------
	logic [THR_W-1:0]           thr_infect = '0;
	logic [THR_W-1:0]           thr_recover = '0;
	logic [NC_W-1:0]            nodes_cfg = 9'd256;
	logic [LFSR_W-1:0]          sim_lfsr = 32'd1;
	logic [ROUND_W-1:0]         sim_rounds = '0;
	int unsigned                sim_last_count = 0;
	bit [MAX_NODES_DEF-1:0]     sim_state = '0;
	int unsigned                sim_degree[MAX_NODES_DEF];
	logic [NODE_W-1:0]          sim_nbr[MAX_NODES_DEF][MAX_DEGREE_DEF];

	initial begin
		foreach (sim_degree[i])
			sim_degree[i] = 0;
	end

	// node count as the block uses it: 0 acts as 1, above the store acts as full
	function automatic int unsigned live_nodes();
		int unsigned n;
		n = nodes_cfg;
		if (n == 0)
			n = 1;
		if (n > MAX_NODES_DEF)
			n = MAX_NODES_DEF;
		return n;
	endfunction

	// one Galois shift, then the top bits against a Q0.16 threshold
	function automatic bit draw_below(logic [THR_W-1:0] thr);
		logic            lsb;
		longint unsigned d;
		lsb = sim_lfsr[0];
		sim_lfsr = sim_lfsr >> 1;
		if (lsb)
			sim_lfsr = sim_lfsr ^ LFSR_TAPS;
		d = longint'(sim_lfsr >> (LFSR_W - DRAW_BITS_DEF));
		return (d << THR_W) < (64'(thr) << DRAW_BITS_DEF);
	endfunction

	task automatic sis_round();
		int unsigned            n;
		int unsigned            nb;
		int unsigned            total;
		bit                     hit;
		bit [MAX_NODES_DEF-1:0] nxt;
		n = live_nodes();
		total = 0;
		nxt = sim_state;
		for (int unsigned i = 0; i < n; i++) begin
			if (!sim_state[i]) begin
				hit = 1'b0;
				// every slot draws, even once a hit is already known
				for (int unsigned j = 0; j < sim_degree[i]; j++) begin
					if (draw_below(thr_infect)) begin
						nb = sim_nbr[i][j];
						if (nb < n && sim_state[nb])
							hit = 1'b1;
					end
				end
				nxt[i] = hit;
			end else begin
				nxt[i] = !draw_below(thr_recover);
			end
		end
		for (int unsigned i = 0; i < n; i++) begin
			sim_state[i] = nxt[i];
			total += nxt[i];
		end
		sim_last_count = total;
		if (sim_rounds < ROUND_MAX)
			sim_rounds++;
	endtask

	// returns the reject flag; a rejected edge leaves the graph untouched
	function automatic logic add_link(int unsigned a, int unsigned b);
		int unsigned n;
		n = live_nodes();
		if (a >= n || b >= n)
			return 1'b1;
		if (a == b) begin
			if (sim_degree[a] + 2 > MAX_DEGREE_DEF)
				return 1'b1;
		end else begin
			if (sim_degree[a] >= MAX_DEGREE_DEF || sim_degree[b] >= MAX_DEGREE_DEF)
				return 1'b1;
		end
		sim_nbr[a][sim_degree[a]] = NODE_W'(b);
		sim_degree[a]++;
		sim_nbr[b][sim_degree[b]] = NODE_W'(a);
		sim_degree[b]++;
		return 1'b0;
	endfunction

	task automatic predict_command(cmd_t op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
			logic sv);
		sis_reply_t r;
		int unsigned n;
		n = live_nodes();
		r.status = 1'b0;
		r.node_state = 1'b0;
		case (op)
			CMD_ADD_EDGE: begin
				r.status = add_link(a, b);
			end
			CMD_SET_STATE: begin
				if (a < n)
					sim_state[a] = sv;
				else
					r.status = 1'b1;
			end
			CMD_RUN_ROUND: begin
				sis_round();
			end
			default: begin
				if (a < n)
					r.node_state = sim_state[a];
				else
					r.status = 1'b1;
			end
		endcase
		r.infected_count = COUNT_W'(sim_last_count);
		r.alive = (sim_last_count != 0);
		r.round_number = sim_rounds;
		expected_replies.push_back(r);
	endtask

	task automatic apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			CFG_INFECT_THR:  thr_infect = data[THR_W-1:0];
			CFG_RECOVER_THR: thr_recover = data[THR_W-1:0];
			CFG_RNG_SEED:    sim_lfsr = (data == '0) ? 32'd1 : data;
			default:         nodes_cfg = data[NC_W-1:0];
		endcase
	endtask

	// ------------------------------------------------------------------
	// Driver: holds start until the item is taken, writes registers only
	// when nothing is in flight, and inserts random gaps before items.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic took;
		logic nxt_start;
		logic nxt_we;
		logic idle_now;
		if (arst_n) begin
			took = start && !busy;
			if (took)
				predict_command(cmd_t'(cmd), node_a, node_b, state_value);
			nxt_start = start && !took;
			nxt_we = 1'b0;
			// results_seen is the pre-edge count; this can only lengthen the wait
			idle_now = !start && (items_sent == results_seen);
			if (!nxt_start && pending_ops.size() != 0) begin
				case (pending_ops[0].kind)
					OP_CMD: begin
						if ($urandom_range(99) >= pending_ops[0].gap_pct) begin
							cmd <= pending_ops[0].op;
							node_a <= pending_ops[0].a;
							node_b <= pending_ops[0].b;
							state_value <= pending_ops[0].sv;
							nxt_start = 1'b1;
							void'(pending_ops.pop_front());
						end
					end
					OP_CFG: begin
						if (idle_now) begin
							cfg_index <= pending_ops[0].idx;
							cfg_wdata <= pending_ops[0].data;
							apply_cfg(pending_ops[0].idx, pending_ops[0].data);
							nxt_we = 1'b1;
							void'(pending_ops.pop_front());
						end
					end
					default: begin
						// pause: let every outstanding result come back first
						if (idle_now)
							void'(pending_ops.pop_front());
					end
				endcase
			end
			start <= nxt_start;
			cfg_we <= nxt_we;
			if (took)
				items_sent <= items_sent + 1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every done cycle is one result item, checked in order.
	// ------------------------------------------------------------------
	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		sis_reply_t want;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (expected_replies.size() == 0) begin
				$error("result item with no command waiting for it");
				errors++;
			end else begin
				want = expected_replies.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("node_state", 32'(want.node_state), 32'(node_state));
				check_field("infected_count", 32'(want.infected_count), 32'(infected_count));
				check_field("alive", 32'(want.alive), 32'(alive));
				check_field("round_number", 32'(want.round_number), 32'(round_number));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus list builders
	// ------------------------------------------------------------------
	task automatic push_cmd(cmd_t op, int unsigned a, int unsigned b, logic sv);
		bench_op_t e;
		e = '{kind: OP_CMD, op: op, a: NODE_W'(a), b: NODE_W'(b), sv: sv,
			idx: '0, data: '0, gap_pct: gap_now};
		pending_ops.push_back(e);
	endtask

	// narrow registers get random junk above their width; the block masks it
	task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val, int unsigned w);
		bench_op_t   e;
		logic [CFG_W-1:0] data;
		data = val;
		if (w < CFG_W)
			data = ($urandom << w) | val;
		e = '{kind: OP_CFG, op: CMD_ADD_EDGE, a: '0, b: '0, sv: 1'b0,
			idx: idx, data: data, gap_pct: 0};
		pending_ops.push_back(e);
	endtask

	task automatic push_drain();
		bench_op_t e;
		e = '{kind: OP_DRAIN, op: CMD_ADD_EDGE, a: '0, b: '0, sv: 1'b0,
			idx: '0, data: '0, gap_pct: 0};
		pending_ops.push_back(e);
	endtask

	function automatic logic [THR_W-1:0] pick_thr();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return THR_W'($urandom_range(65535));
		endcase
	endfunction

	// mostly an active node, now and then any index at all
	function automatic int unsigned pick_node(int unsigned live);
		if ($urandom_range(9) == 0)
			return $urandom_range(255);
		return $urandom_range(live - 1);
	endfunction

	// one stretch of random work under one register setting
	task automatic random_episode(int unsigned nc_raw, int unsigned len, int unsigned add_pct);
		int unsigned live;
		int unsigned r;
		logic [CFG_W-1:0] seed;
		live = (nc_raw == 0) ? 1 : (nc_raw > MAX_NODES_DEF) ? MAX_NODES_DEF : nc_raw;
		push_cfg(CFG_INFECT_THR, CFG_W'(pick_thr()), THR_W);
		push_cfg(CFG_RECOVER_THR, CFG_W'(pick_thr()), THR_W);
		if ($urandom_range(1)) begin
			seed = ($urandom_range(7) == 0) ? '0 : CFG_W'($urandom);
			push_cfg(CFG_RNG_SEED, seed, CFG_W);
		end
		push_cfg(CFG_NODE_COUNT, CFG_W'(nc_raw), NC_W);
		for (int unsigned k = 0; k < len; k++) begin
			r = $urandom_range(99);
			if (r < add_pct)
				push_cmd(CMD_ADD_EDGE, pick_node(live), pick_node(live), $urandom_range(1));
			else if (r < add_pct + (100 - add_pct) * 4 / 10)
				push_cmd(CMD_SET_STATE, pick_node(live), $urandom_range(255),
					$urandom_range(1));
			else if (r < add_pct + (100 - add_pct) * 7 / 10)
				push_cmd(CMD_RUN_ROUND, $urandom_range(255), $urandom_range(255),
					$urandom_range(1));
			else
				push_cmd(CMD_READ_STATE, pick_node(live), $urandom_range(255),
					$urandom_range(1));
		end
	endtask

	initial begin
		int unsigned nc_raw;

		// ---- directed part, small graph of four nodes ----
		gap_now = 13;
		push_cfg(CFG_NODE_COUNT, 32'd4, NC_W);
		push_cfg(CFG_INFECT_THR, 32'd0, THR_W);
		push_cfg(CFG_RECOVER_THR, 32'd0, THR_W);
		push_cfg(CFG_RNG_SEED, 32'd1, CFG_W);
		push_cmd(CMD_READ_STATE, 0, 0, 1'b0);
		push_cmd(CMD_READ_STATE, 4, 255, 1'b1);     // just past the node count
		push_cmd(CMD_READ_STATE, 255, 0, 1'b0);
		push_cmd(CMD_SET_STATE, 0, 0, 1'b1);
		push_cmd(CMD_SET_STATE, 200, 0, 1'b1);      // out of range, no change
		push_cmd(CMD_READ_STATE, 0, 0, 1'b0);
		push_cmd(CMD_ADD_EDGE, 0, 1, 1'b0);
		push_cmd(CMD_ADD_EDGE, 1, 2, 1'b0);
		push_cmd(CMD_ADD_EDGE, 3, 3, 1'b0);         // self loop, two slots
		push_cmd(CMD_ADD_EDGE, 0, 1, 1'b0);         // duplicate edge
		push_cmd(CMD_ADD_EDGE, 0, 4, 1'b0);         // bad endpoint
		push_cmd(CMD_ADD_EDGE, 255, 255, 1'b1);
		push_cmd(CMD_RUN_ROUND, 0, 0, 1'b0);        // zero thresholds: nothing moves
		// full-scale infection, no recovery
		push_cfg(CFG_INFECT_THR, 32'hFFFF, THR_W);
		push_cmd(CMD_RUN_ROUND, 0, 0, 1'b0);
		push_cmd(CMD_READ_STATE, 1, 0, 1'b0);
		// full-scale recovery, zero seed falls back to one
		push_cfg(CFG_RECOVER_THR, 32'hFFFF, THR_W);
		push_cfg(CFG_RNG_SEED, 32'd0, CFG_W);
		push_cmd(CMD_RUN_ROUND, 0, 0, 1'b0);
		push_cmd(CMD_SET_STATE, 1, 0, 1'b1);
		// node count zero acts as one: node 1 becomes a stale neighbor of node 0
		push_cfg(CFG_NODE_COUNT, 32'd0, NC_W);
		push_cmd(CMD_SET_STATE, 0, 0, 1'b0);
		push_cmd(CMD_RUN_ROUND, 0, 0, 1'b0);
		push_cmd(CMD_READ_STATE, 1, 0, 1'b0);
		// above the store size acts as the full store
		push_cfg(CFG_NODE_COUNT, 32'd511, NC_W);
		push_cmd(CMD_READ_STATE, 255, 0, 1'b0);
		push_cmd(CMD_SET_STATE, 255, 0, 1'b1);
		push_cmd(CMD_ADD_EDGE, 255, 254, 1'b0);
		push_cmd(CMD_RUN_ROUND, 0, 0, 1'b0);
		push_drain();

		// ---- random part, three gap settings ----
		for (int unsigned ph = 0; ph < 3; ph++) begin
			gap_now = (ph == 0) ? 13 : (ph == 1) ? 50 : 0;
			for (int unsigned ep = 0; ep < 3; ep++) begin
				if (ph == 0 && ep == 0) begin
					// two nodes and mostly edges: degrees run full
					random_episode(2, 36, 80);
				end else begin
					case ($urandom_range(7))
						0:       nc_raw = $urandom_range(1) ? 256 : $urandom_range(257, 511);
						1:       nc_raw = $urandom_range(1);
						default: nc_raw = $urandom_range(3, 32);
					endcase
					random_episode(nc_raw, 5, 30);
				end
				if (ep == 1)
					push_drain();
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_ops.size() != 0 || start || items_sent != results_seen);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_replies.size() != 0) begin
			$error("%0d expected result items never arrived", expected_replies.size());
			errors++;
		end
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
design/sis_pkg.sv
design/sis_epidemic_graph_step_top.sv
bench/tb_sis_epidemic_graph_step_top.sv
